// ----- design/vtcg_pkg.sv -----
// Shared types, codes and arithmetic helpers for the vario tone cadence generator.
package vtcg_pkg;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_WRITE  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SEL_FREQ   = 2'd0,
    SEL_LENGTH = 2'd1,
    SEL_PAUSE  = 2'd2,
    SEL_NONE   = 2'd3
  } sel_t;

  typedef enum logic [1:0] {
    CFG_LIFT   = 2'd0,
    CFG_SINK   = 2'd1,
    CFG_VOLUME = 2'd2,
    CFG_FLUID  = 2'd3
  } cfg_idx_t;

  localparam logic [11:0] LIFT_RESET   = 12'sd10;
  localparam logic [11:0] SINK_RESET   = -12'sd200;
  localparam logic [6:0]  VOLUME_RESET = 7'd100;
  localparam logic [23:0] DIV10_MUL    = 24'hCCCCCD;
  localparam int          DIV10_SHIFT  = 27;

  function automatic logic [15:0] interp(input logic [15:0] a, input logic [15:0] b,
                                         input logic [7:0] f);
    logic [8:0]  fa;
    logic [24:0] sum;
    fa  = 9'd256 - {1'b0, f};
    sum = 25'(a * fa) + 25'(b * {1'b0, f});
    return sum[23:8];
  endfunction

  function automatic logic [15:0] to_ticks(input logic [15:0] ms);
    logic [20:0] t;
    t = {ms, 5'd0} - {5'd0, ms};
    return (t > 21'd65535) ? 16'hFFFF : t[15:0];
  endfunction

endpackage

// ----- design/vario_tone_cadence_generator.sv -----
// Top level of the vario tone cadence generator with its table memories and cadence state.
//
// The input channel takes one word per handshake: a climb sample, a timer tick or a
// table write, selected by in_opcode. Every accepted word yields exactly one result
// word on the output channel with the buzzer frequency, level and cadence flags as
// they stand after that word. Thresholds, volume and fluid mode are written on the
// cfg_ port by the user only while the block is idle; the block itself does not enforce it.
// The three tables live in synchronous memories read at two points each when a
// sample is accepted. The read data is registered with the word, then the
// interpolated table values, and then the cadence state with the result word.
// One word is accepted every cycle while results are taken.
// When the receiver stalls, the output register holds its word and in_ready falls
// in the same cycle, freezing the whole pipeline until the word is taken.
// Reset clears the cadence state, the pipeline and the output register and loads
// the register defaults. Table contents are undefined until they are written.
module vario_tone_cadence_generator #(
  parameter int TABLE_POINTS = 41
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic signed [15:0] in_climb_rate,
  input  logic [1:0]  in_table_select,
  input  logic [5:0]  in_table_index,
  input  logic [15:0] in_table_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_freq,
  output logic [6:0]  out_level,
  output logic        out_silent_phase,
  output logic        out_cadence_on,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int AW = $clog2(TABLE_POINTS);
  localparam int CENTRE = (TABLE_POINTS - 1) / 2;
  localparam int TOP = TABLE_POINTS - 2;

  logic signed [11:0] lift_r, sink_r;
  logic [6:0]         volume_r;
  logic               fluid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lift_r   <= vtcg_pkg::LIFT_RESET;
      sink_r   <= vtcg_pkg::SINK_RESET;
      volume_r <= vtcg_pkg::VOLUME_RESET;
      fluid_r  <= 1'b0;
    end else if (cfg_we) begin
      case (vtcg_pkg::cfg_idx_t'(cfg_index))
        vtcg_pkg::CFG_LIFT:   lift_r   <= cfg_data;
        vtcg_pkg::CFG_SINK:   sink_r   <= cfg_data;
        vtcg_pkg::CFG_VOLUME: volume_r <= cfg_data[6:0];
        vtcg_pkg::CFG_FLUID:  fluid_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic stall, accept, advance;
  assign stall   = out_valid && !out_ready;
  assign advance = !stall;
  assign in_ready = advance;
  assign accept  = in_valid && in_ready;

  // Point selection and threshold tests for the incoming sample.
  logic signed [8:0]  k;
  logic [AW-1:0]      addr_a, addr_b, waddr;
  logic [7:0]         frac;
  logic signed [24:0] climb_x100, lift_x512, sink_x512;
  logic               is_lift, is_sink, rd_en, wr_ok;

  always_comb begin
    k = 9'(in_climb_rate >>> 8) + 9'(CENTRE);
    if (k > 9'sd0 + 9'(TOP)) begin
      addr_a = AW'(TABLE_POINTS - 1);
      addr_b = AW'(TABLE_POINTS - 1);
      frac   = 8'd0;
    end else if (k < 9'sd0) begin
      addr_a = '0;
      addr_b = '0;
      frac   = 8'd0;
    end else begin
      addr_a = AW'(k);
      addr_b = AW'(k + 9'sd1);
      frac   = in_climb_rate[7:0];
    end
    climb_x100 = 25'(in_climb_rate) * 25'sd100;
    lift_x512  = 25'(lift_r) <<< 9;
    sink_x512  = 25'(sink_r) <<< 9;
    is_lift = (volume_r != 7'd0) && (climb_x100 >= lift_x512);
    is_sink = (volume_r != 7'd0) && !is_lift && (climb_x100 <= sink_x512);
    rd_en = accept && (vtcg_pkg::op_t'(in_opcode) == vtcg_pkg::OP_SAMPLE);
    wr_ok = accept && (vtcg_pkg::op_t'(in_opcode) == vtcg_pkg::OP_WRITE)
            && (32'(in_table_index) < TABLE_POINTS);
    waddr = AW'(in_table_index);
  end

  logic [15:0] freq_mem  [TABLE_POINTS];
  logic [15:0] len_mem   [TABLE_POINTS];
  logic [15:0] pause_mem [TABLE_POINTS];
  logic [15:0] fa_r, fb_r, la_r, lb_r, pa_r, pb_r;

  always_ff @(posedge clk) begin
    if (wr_ok && vtcg_pkg::sel_t'(in_table_select) == vtcg_pkg::SEL_FREQ) begin
      freq_mem[waddr] <= in_table_value;
    end
    if (rd_en) begin
      fa_r <= freq_mem[addr_a];
      fb_r <= freq_mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok && vtcg_pkg::sel_t'(in_table_select) == vtcg_pkg::SEL_LENGTH) begin
      len_mem[waddr] <= in_table_value;
    end
    if (rd_en) begin
      la_r <= len_mem[addr_a];
      lb_r <= len_mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok && vtcg_pkg::sel_t'(in_table_select) == vtcg_pkg::SEL_PAUSE) begin
      pause_mem[waddr] <= in_table_value;
    end
    if (rd_en) begin
      pa_r <= pause_mem[addr_a];
      pb_r <= pause_mem[addr_b];
    end
  end

  // Stage one: read data arrives.
  logic        s1_v_r;
  vtcg_pkg::op_t s1_op_r;
  logic [7:0]  s1_frac_r;
  logic        s1_lift_r, s1_sink_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (advance) begin
      s1_v_r <= accept;
    end
    if (accept) begin
      s1_op_r   <= vtcg_pkg::op_t'(in_opcode);
      s1_frac_r <= frac;
      s1_lift_r <= is_lift;
      s1_sink_r <= is_sink;
    end
  end

  // Stage two: interpolated table values.
  logic        s2_v_r;
  vtcg_pkg::op_t s2_op_r;
  logic [15:0] s2_fr_r, s2_ln_r, s2_pa_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (advance) begin
      s2_v_r <= s1_v_r;
    end
    if (advance && s1_v_r) begin
      s2_op_r <= s1_op_r;
      s2_fr_r <= (s1_lift_r || s1_sink_r) ? vtcg_pkg::interp(fa_r, fb_r, s1_frac_r) : 16'd0;
      s2_ln_r <= s1_lift_r ? vtcg_pkg::interp(la_r, lb_r, s1_frac_r) : 16'd0;
      s2_pa_r <= s1_lift_r ? vtcg_pkg::interp(pa_r, pb_r, s1_frac_r) : 16'd0;
    end
  end

  // Stage three: tone smoothing and cadence state.
  logic [23:0] sm_r, sm_nxt;
  logic [15:0] snd_r, snd_nxt, sil_r, sil_nxt, cnt_r, cnt_nxt, lim_r, lim_nxt;
  logic [15:0] df_r, df_nxt;
  logic [6:0]  lvl_r, lvl_nxt;
  logic        con_r, con_nxt, insil_r, insil_nxt;
  logic signed [24:0] diff;
  logic [23:0] absd, quo, sm_new;
  logic [47:0] prod;

  always_comb begin
    sm_nxt    = sm_r;
    snd_nxt   = snd_r;
    sil_nxt   = sil_r;
    cnt_nxt   = cnt_r;
    lim_nxt   = lim_r;
    df_nxt    = df_r;
    lvl_nxt   = lvl_r;
    con_nxt   = con_r;
    insil_nxt = insil_r;
    diff   = $signed({1'b0, s2_fr_r, 8'd0}) - $signed({1'b0, sm_r});
    absd   = diff[24] ? 24'(-diff) : diff[23:0];
    prod   = 48'(absd) * 48'(vtcg_pkg::DIV10_MUL);
    quo    = 24'(prod >> vtcg_pkg::DIV10_SHIFT);
    sm_new = (sm_r == 24'd0) ? {s2_fr_r, 8'd0} : (diff[24] ? sm_r - quo : sm_r + quo);
    case (s2_op_r)
      vtcg_pkg::OP_SAMPLE: begin
        if (s2_fr_r == 16'd0) begin
          sm_nxt = 24'd0;
          if (!con_r) begin
            lvl_nxt = 7'd0;
          end
        end else begin
          sm_nxt = sm_new;
          if (!con_r) begin
            df_nxt  = sm_new[23:8];
            lvl_nxt = volume_r;
          end
          if (fluid_r && !insil_r) begin
            df_nxt = sm_new[23:8];
          end
        end
        if (s2_ln_r == 16'd0 || s2_pa_r == 16'd0) begin
          snd_nxt = 16'd0;
          sil_nxt = 16'd0;
        end else begin
          snd_nxt = vtcg_pkg::to_ticks(s2_ln_r);
          sil_nxt = vtcg_pkg::to_ticks(s2_pa_r);
          if (!con_r) begin
            cnt_nxt   = 16'd1;
            df_nxt    = sm_nxt[23:8];
            lvl_nxt   = volume_r;
            lim_nxt   = snd_nxt;
            insil_nxt = 1'b0;
          end
          con_nxt = 1'b1;
        end
      end
      vtcg_pkg::OP_TICK: begin
        if (con_r) begin
          if (cnt_r >= lim_r) begin
            cnt_nxt = 16'd0;
            if (!insil_r) begin
              lvl_nxt = 7'd0;
              if (sil_r == 16'd0) begin
                con_nxt = 1'b0;
              end else begin
                lim_nxt   = sil_r;
                insil_nxt = 1'b1;
              end
            end else begin
              if (sm_r != 24'd0) begin
                df_nxt  = sm_r[23:8];
                lvl_nxt = volume_r;
              end
              if (snd_r == 16'd0) begin
                con_nxt = 1'b0;
              end else begin
                lim_nxt   = snd_r;
                insil_nxt = 1'b0;
              end
            end
          end else begin
            cnt_nxt = cnt_r + 16'd1;
          end
        end
      end
      default: ;
    endcase
  end

  logic out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sm_r    <= '0;
      snd_r   <= '0;
      sil_r   <= '0;
      cnt_r   <= '0;
      lim_r   <= '0;
      df_r    <= '0;
      lvl_r   <= '0;
      con_r   <= 1'b0;
      insil_r <= 1'b0;
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= s2_v_r;
      if (s2_v_r) begin
        sm_r    <= sm_nxt;
        snd_r   <= snd_nxt;
        sil_r   <= sil_nxt;
        cnt_r   <= cnt_nxt;
        lim_r   <= lim_nxt;
        df_r    <= df_nxt;
        lvl_r   <= lvl_nxt;
        con_r   <= con_nxt;
        insil_r <= insil_nxt;
      end
    end
  end

  assign out_valid        = out_v_r;
  assign out_freq         = df_r;
  assign out_level        = lvl_r;
  assign out_cadence_on   = con_r;
  assign out_silent_phase = con_r && insil_r;

endmodule

// ----- design/vtcg_checker.sv -----
// Port-level assertions for the vario tone cadence generator and their bind.
module vtcg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_freq,
  input logic [6:0]  out_level,
  input logic        out_silent_phase,
  input logic        out_cadence_on
);

  // The pause phase is only reported while the cadence runs.
  a_silent_needs_cadence: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_silent_phase || out_cadence_on))
    else $error("pause phase shown without a running cadence");

  // A stalled result word freezes the input side.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while the result word is stalled");

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word offered right after reset");

  a_stalled_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_freq) && $stable(out_level)
      && $stable(out_silent_phase) && $stable(out_cadence_on)))
    else $error("stalled result word changed");

endmodule

bind vario_tone_cadence_generator vtcg_checker u_vtcg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_freq         (out_freq),
  .out_level        (out_level),
  .out_silent_phase (out_silent_phase),
  .out_cadence_on   (out_cadence_on)
);

// ----- tb/vario_tone_cadence_generator_tb.sv -----
// Testbench for the vario tone cadence generator: directed and random words checked against a predictor.
module vario_tone_cadence_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POINTS = 41;
  localparam int CENTRE = (POINTS - 1) / 2;

  typedef struct packed {
    logic [15:0] freq;
    logic [6:0]  level;
    logic        silent;
    logic        cad_on;
  } drive_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] in_opcode = 0;
  logic signed [15:0] in_climb_rate = 0;
  logic [1:0] in_table_select = 0;
  logic [5:0] in_table_index = 0;
  logic [15:0] in_table_value = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [15:0] out_freq;
  logic [6:0] out_level;
  logic out_silent_phase;
  logic out_cadence_on;
  logic cfg_we = 0;
  logic [1:0] cfg_index = 0;
  logic [11:0] cfg_data = 0;

  vario_tone_cadence_generator dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state.
  int lift_cm, sink_cm;
  int unsigned vol, fluid;
  logic [15:0] freq_tab[POINTS], len_tab[POINTS], pause_tab[POINTS];
  int unsigned smooth_q8, beep_ticks, gap_ticks, count, limit, drv_freq, drv_level;
  bit running, quiet;

  drive_t expected_drive[$];
  int errors = 0;
  bit filled = 0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic int unsigned table_read(input logic [15:0] tab[POINTS], input int c);
    int k;
    int unsigned f;
    k = (c >>> 8) + CENTRE;
    f = c & 255;
    if (k > POINTS - 2) return tab[POINTS - 1];
    if (k < 0) return tab[0];
    return (tab[k] * (256 - f) + tab[k + 1] * f) >> 8;
  endfunction

  function automatic int unsigned ms_ticks(input int unsigned ms);
    return (ms * 31 > 65535) ? 65535 : ms * 31;
  endfunction

  function automatic void apply_tone(input int unsigned tone);
    int diff;
    if (tone == 0) begin
      smooth_q8 = 0;
      if (!running) drv_level = 0;
      return;
    end
    if (smooth_q8 != 0) begin
      diff = int'(tone << 8) - int'(smooth_q8);
      smooth_q8 = int'(smooth_q8) + diff / 10;
    end else begin
      smooth_q8 = tone << 8;
    end
    smooth_q8 &= 24'hFFFFFF;
    if (!running) begin
      drv_freq = smooth_q8 >> 8;
      drv_level = vol;
    end
    if (fluid != 0 && !quiet) drv_freq = smooth_q8 >> 8;
  endfunction

  function automatic void apply_cadence(input int unsigned ln, input int unsigned pa);
    if (ln == 0 || pa == 0) begin
      beep_ticks = 0;
      gap_ticks = 0;
      return;
    end
    beep_ticks = ms_ticks(ln);
    gap_ticks = ms_ticks(pa);
    if (!running) begin
      count = 1;
      drv_freq = smooth_q8 >> 8;
      drv_level = vol;
      limit = beep_ticks;
      quiet = 0;
    end
    running = 1;
  endfunction

  function automatic void phase_switch();
    if (!quiet) begin
      drv_level = 0;
      if (gap_ticks == 0) begin
        running = 0;
        return;
      end
      limit = gap_ticks;
      quiet = 1;
    end else begin
      if (smooth_q8 > 0) begin
        drv_freq = smooth_q8 >> 8;
        drv_level = vol;
      end
      if (beep_ticks == 0) begin
        running = 0;
        return;
      end
      limit = beep_ticks;
      quiet = 0;
    end
  endfunction

  function automatic drive_t predict_drive(input vtcg_pkg::op_t op, input int c,
                                           input vtcg_pkg::sel_t sel,
                                           input int idx, input logic [15:0] val);
    int unsigned fr, ln, pa;
    drive_t d;
    fr = 0;
    ln = 0;
    pa = 0;
    case (op)
      vtcg_pkg::OP_SAMPLE: begin
        if (vol > 0) begin
          if (c * 100 >= lift_cm * 512) begin
            fr = table_read(freq_tab, c);
            ln = table_read(len_tab, c);
            pa = table_read(pause_tab, c);
          end else if (c * 100 <= sink_cm * 512) begin
            fr = table_read(freq_tab, c);
          end
        end
        apply_tone(fr);
        apply_cadence(ln, pa);
      end
      vtcg_pkg::OP_TICK: begin
        if (running) begin
          if (count >= limit) begin
            count = 0;
            phase_switch();
          end else begin
            count = (count + 1) & 16'hFFFF;
          end
        end
      end
      vtcg_pkg::OP_WRITE: begin
        if (idx < POINTS) begin
          if (sel == vtcg_pkg::SEL_FREQ) freq_tab[idx] = val;
          else if (sel == vtcg_pkg::SEL_LENGTH) len_tab[idx] = val;
          else if (sel == vtcg_pkg::SEL_PAUSE) pause_tab[idx] = val;
        end
      end
      default: ;
    endcase
    d.freq = drv_freq[15:0];
    d.level = drv_level[6:0];
    d.silent = running && quiet;
    d.cad_on = running;
    return d;
  endfunction

  task automatic send_word(input vtcg_pkg::op_t op, input logic signed [15:0] c,
                           input vtcg_pkg::sel_t sel, input logic [5:0] idx,
                           input logic [15:0] val);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_climb_rate <= c;
    in_table_select <= sel;
    in_table_index <= idx;
    in_table_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_drive.push_back(predict_drive(op, int'(c), sel, int'(idx), val));
    @(negedge clk);
  endtask

  task automatic write_reg(input vtcg_pkg::cfg_idx_t idx, input logic [11:0] val);
    in_valid <= 1'b0;
    while (expected_drive.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      vtcg_pkg::CFG_LIFT: lift_cm = int'($signed(val));
      vtcg_pkg::CFG_SINK: sink_cm = int'($signed(val));
      vtcg_pkg::CFG_VOLUME: vol = int'(val[6:0]);
      default: fluid = int'(val[0]);
    endcase
  endtask

  always @(posedge clk) begin
    drive_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_drive.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        e = expected_drive.pop_front();
        if (out_freq !== e.freq) report("out_freq", int'(out_freq), int'(e.freq));
        if (out_level !== e.level) report("out_level", int'(out_level), int'(e.level));
        if (out_silent_phase !== e.silent)
          report("out_silent_phase", int'(out_silent_phase), int'(e.silent));
        if (out_cadence_on !== e.cad_on)
          report("out_cadence_on", int'(out_cadence_on), int'(e.cad_on));
      end
    end
  end

  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1;
      end else begin
        gap = (filled || $urandom_range(0, 1)) ? $urandom_range(0, 19) : 0;
        if (gap != 0) begin
          out_ready <= 0;
          repeat (gap) @(negedge clk);
        end
        out_ready <= 1;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
    end
  end

  task automatic fill_tables();
    for (int i = 0; i < POINTS; i++) begin
      send_word(vtcg_pkg::OP_WRITE, 16'sd0, vtcg_pkg::SEL_FREQ, 6'(i),
                16'($urandom_range(0, 1) ? $urandom : 400 + 30 * i));
      send_word(vtcg_pkg::OP_WRITE, 16'sd0, vtcg_pkg::SEL_LENGTH, 6'(i),
                16'($urandom_range(0, 5) ? $urandom_range(0, 40) : $urandom));
      send_word(vtcg_pkg::OP_WRITE, 16'sd0, vtcg_pkg::SEL_PAUSE, 6'(i),
                16'($urandom_range(0, 5) ? $urandom_range(0, 40) : $urandom));
    end
    filled = 1;
  endtask

  task automatic test_directed();
    send_word(vtcg_pkg::OP_WRITE, 16'sd0, vtcg_pkg::SEL_FREQ, 6'd40, 16'hFFFF);
    send_word(vtcg_pkg::OP_WRITE, 16'sd0, vtcg_pkg::SEL_LENGTH, 6'd40, 16'hFFFF);
    send_word(vtcg_pkg::OP_WRITE, 16'sd0, vtcg_pkg::SEL_PAUSE, 6'd0, 16'h0000);
    send_word(vtcg_pkg::OP_WRITE, 16'sd0, vtcg_pkg::SEL_NONE, 6'd5, 16'h1234);
    send_word(vtcg_pkg::OP_WRITE, 16'sd0, vtcg_pkg::SEL_FREQ, 6'd41, 16'h5555);
    send_word(vtcg_pkg::OP_WRITE, 16'sd0, vtcg_pkg::SEL_FREQ, 6'd63, 16'hAAAA);
    send_word(vtcg_pkg::OP_SAMPLE, 16'sh7FFF, vtcg_pkg::SEL_FREQ, 6'd0, 16'd0);
    send_word(vtcg_pkg::OP_SAMPLE, -16'sh8000, vtcg_pkg::SEL_FREQ, 6'd0, 16'd0);
    send_word(vtcg_pkg::OP_SAMPLE, 16'sd0, vtcg_pkg::SEL_FREQ, 6'd0, 16'd0);
    send_word(vtcg_pkg::OP_SAMPLE, 16'sd1000, vtcg_pkg::SEL_FREQ, 6'd0, 16'd0);
    repeat (6) send_word(vtcg_pkg::OP_TICK, 16'sd0, vtcg_pkg::SEL_FREQ, 6'd0, 16'd0);
    send_word(vtcg_pkg::OP_NONE, 16'sh5A5A, vtcg_pkg::SEL_PAUSE, 6'd40, 16'hFFFF);
    send_word(vtcg_pkg::OP_SAMPLE, -16'sd2000, vtcg_pkg::SEL_FREQ, 6'd0, 16'd0);
  endtask

  task automatic test_random(input int n);
    int r;
    logic signed [15:0] c;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      c = ($urandom_range(0, 4) == 0) ? 16'($urandom) :
          16'($signed($urandom_range(0, 8000)) - 3000);
      if (r < 35) send_word(vtcg_pkg::OP_SAMPLE, c, vtcg_pkg::SEL_FREQ, 6'd0, 16'd0);
      else if (r < 88)
        send_word(vtcg_pkg::OP_TICK, 16'($urandom), vtcg_pkg::sel_t'($urandom_range(0, 3)),
                  6'($urandom), 16'($urandom));
      else if (r < 95)
        send_word(vtcg_pkg::OP_WRITE, 16'sd0, vtcg_pkg::sel_t'($urandom_range(0, 2)),
                  6'($urandom_range(0, 40)), 16'($urandom));
      else if (r < 98)
        send_word(vtcg_pkg::OP_WRITE, 16'sd0, vtcg_pkg::SEL_NONE, 6'($urandom),
                  16'($urandom));
      else
        send_word(vtcg_pkg::OP_NONE, 16'($urandom), vtcg_pkg::sel_t'($urandom_range(0, 3)),
                  6'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_settings();
    write_reg(vtcg_pkg::CFG_FLUID, 12'd1);
    write_reg(vtcg_pkg::CFG_LIFT, 12'h800);
    write_reg(vtcg_pkg::CFG_SINK, 12'h7FF);
    test_random(150);
    write_reg(vtcg_pkg::CFG_LIFT, 12'd2000);
    write_reg(vtcg_pkg::CFG_SINK, -12'sd2000);
    write_reg(vtcg_pkg::CFG_VOLUME, 12'd0);
    test_random(80);
    write_reg(vtcg_pkg::CFG_VOLUME, 12'd127);
    write_reg(vtcg_pkg::CFG_LIFT, -12'sd2000);
    write_reg(vtcg_pkg::CFG_FLUID, 12'd0);
    test_random(150);
    write_reg(vtcg_pkg::CFG_VOLUME, 12'd1);
    write_reg(vtcg_pkg::CFG_LIFT, 12'd5);
    write_reg(vtcg_pkg::CFG_SINK, 12'd2000);
    test_random(100);
    write_reg(vtcg_pkg::CFG_VOLUME, 12'd100);
    write_reg(vtcg_pkg::CFG_SINK, -12'sd100);
    write_reg(vtcg_pkg::CFG_FLUID, 12'd1);
    test_random(150);
  endtask

  initial begin
    lift_cm = 10;
    sink_cm = -200;
    vol = 100;
    fluid = 0;
    smooth_q8 = 0; beep_ticks = 0; gap_ticks = 0; count = 0; limit = 0;
    drv_freq = 0; drv_level = 0; running = 0; quiet = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1;
    fill_tables();
    test_directed();
    test_random(150);
    test_settings();
    in_valid <= 1'b0;
    while (expected_drive.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("[vario_tone_cadence_generator] OK");
    end else begin
      $display("[vario_tone_cadence_generator] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[vario_tone_cadence_generator] ERROR");
    $finish;
  end
endmodule

// ----- vario_tone_cadence_generator.f -----
design/vtcg_pkg.sv
design/vario_tone_cadence_generator.sv
design/vtcg_checker.sv
tb/vario_tone_cadence_generator_tb.sv
